@@ rtl/core/ttg_pkg.sv @@
`timescale 1ns / 1ps

package ttg_pkg;

   // Field and register widths.
   localparam int TypeWidth  = 5;
   localparam int CodeWidth  = 10;
   localparam int ValueWidth = 32;
   localparam int CsrWidth   = 12;
   localparam int CsrIdxWidth = 3;

   // Highest key code that may leave the block.
   localparam logic [CodeWidth-1:0] KEY_CODE_LIMIT = 10'd767;

   // Event classes.
   localparam logic [TypeWidth-1:0] EV_SYNC = 5'd0;
   localparam logic [TypeWidth-1:0] EV_KEY  = 5'd1;
   localparam logic [TypeWidth-1:0] EV_REL  = 5'd2;
   localparam logic [TypeWidth-1:0] EV_ABS  = 5'd3;

   // Event codes.
   localparam logic [CodeWidth-1:0] REL_Y_CODE    = 10'd1;
   localparam logic [CodeWidth-1:0] ABS_X_CODE    = 10'd53;
   localparam logic [CodeWidth-1:0] ABS_Y_CODE    = 10'd54;
   localparam logic [CodeWidth-1:0] TRACK_ID_CODE = 10'd57;

   // Emitted key codes.
   localparam logic [CodeWidth-1:0] BTN_UP    = 10'd103;
   localparam logic [CodeWidth-1:0] BTN_DOWN  = 10'd108;
   localparam logic [CodeWidth-1:0] BTN_POWER = 10'd116;
   localparam logic [CodeWidth-1:0] BTN_BACK  = 10'd158;

   // Gesture thresholds.
   localparam logic signed [ValueWidth-1:0] TRACK_POS_LIMIT = 32'sd3;
   localparam logic signed [ValueWidth-1:0] TRACK_NEG_LIMIT = -32'sd3;
   localparam logic signed [ValueWidth-1:0] VERT_POS_LIMIT  = 32'sd40;
   localparam logic signed [ValueWidth-1:0] VERT_NEG_LIMIT  = -32'sd40;
   localparam logic signed [ValueWidth-1:0] LIFT_ID         = -32'sd1;

   // Configuration register indexes.
   localparam logic [CsrIdxWidth-1:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_KEYBAR_WIDTH  = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_KEYBAR_HEIGHT = 3'd3;

   // Configuration reset values.
   localparam logic [CsrWidth-1:0] SCREEN_WIDTH_RST  = 12'd480;
   localparam logic [CsrWidth-1:0] SCREEN_HEIGHT_RST = 12'd800;
   localparam logic [CsrWidth-1:0] KEYBAR_WIDTH_RST  = 12'd480;
   localparam logic [CsrWidth-1:0] KEYBAR_HEIGHT_RST = 12'd72;

endpackage

@@ rtl/core/touch_trackball_gesture_to_key.sv @@
`timescale 1ns / 1ps
// A word accepted at a clock edge is registered in the input register and then in the
// result register, which drives the rsp channel (two register stages: input register, result register).
// Throughput: one word per cycle, limited only by rsp_stall on the result register.
// Reset: synchronous, active high; clears valids, gesture state and restores
// the configuration registers to their default screen geometry.
module touch_trackball_gesture_to_key (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [ttg_pkg::TypeWidth-1:0]          req_event_type,
   input  logic [ttg_pkg::CodeWidth-1:0]          req_event_code,
   input  logic signed [ttg_pkg::ValueWidth-1:0]  req_event_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [ttg_pkg::CodeWidth-1:0]          rsp_key_code,
   output logic signed [ttg_pkg::ValueWidth-1:0]  rsp_key_value,
   output logic                                   rsp_synthetic,
   input  logic                                   csr_wr_en,
   input  logic [ttg_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [ttg_pkg::CsrWidth-1:0]           csr_wr_data
);

   // Configuration registers.
   logic [ttg_pkg::CsrWidth-1:0] screen_width_ff, screen_height_ff;
   logic [ttg_pkg::CsrWidth-1:0] keybar_width_ff, keybar_height_ff;

   // Input register.
   logic                                  in_valid_ff;
   logic [ttg_pkg::TypeWidth-1:0]         in_type_ff;
   logic [ttg_pkg::CodeWidth-1:0]         in_code_ff;
   logic signed [ttg_pkg::ValueWidth-1:0] in_value_ff;

   // Gesture state.
   logic signed [ttg_pkg::ValueWidth-1:0] tb_sum_ff, tb_sum_in;
   logic finger_down_ff, finger_down_in;
   logic swipe_right_ff, swipe_right_in;
   logic swipe_left_ff, swipe_left_in;
   logic signed [ttg_pkg::ValueWidth-1:0] pos_x_ff, pos_x_in;
   logic signed [ttg_pkg::ValueWidth-1:0] pos_y_ff, pos_y_in;
   logic signed [ttg_pkg::ValueWidth-1:0] motion_x_ff, motion_x_in;
   logic signed [ttg_pkg::ValueWidth-1:0] motion_y_ff, motion_y_in;

   // Result register.
   logic                                  rsp_valid_ff;
   logic [ttg_pkg::CodeWidth-1:0]         rsp_code_ff;
   logic signed [ttg_pkg::ValueWidth-1:0] rsp_value_ff;
   logic                                  rsp_synth_ff;

   // Result of the current word.
   logic                                  res_valid;
   logic [ttg_pkg::CodeWidth-1:0]         res_code;
   logic signed [ttg_pkg::ValueWidth-1:0] res_value;
   logic                                  res_synth;

   // Handshake control.
   logic out_free, advance;

   // Geometry derived from configuration.
   logic signed [12:0] bar_top13, ko_diff, ko_adj, ko13;
   logic signed [ttg_pkg::ValueWidth-1:0] bar_top, ko32, kw32, q32, neg_q32;
   logic signed [ttg_pkg::ValueWidth-1:0] th_down, th_up, th_back;
   logic signed [ttg_pkg::ValueWidth-1:0] sum_add, mx_add, my_add;
   logic [ttg_pkg::CodeWidth-1:0] bar_code;
   logic bar_hit;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_code  = rsp_code_ff;
   assign rsp_key_value = rsp_value_ff;
   assign rsp_synthetic = rsp_synth_ff;

   // Bar top, key width, key offset (rounded toward zero) and swipe threshold.
   always_comb begin
      bar_top13 = $signed({1'b0, screen_height_ff}) - $signed({1'b0, keybar_height_ff});
      bar_top   = {{19{bar_top13[12]}}, bar_top13};
      ko_diff   = $signed({1'b0, screen_width_ff}) - $signed({1'b0, keybar_width_ff});
      ko_adj    = ko_diff + $signed({12'b0, ko_diff[12]});
      ko13      = ko_adj >>> 1;
      ko32      = {{19{ko13[12]}}, ko13};
      kw32      = $signed({22'b0, keybar_width_ff[11:2]});
      th_down   = kw32 + ko32;
      th_up     = (kw32 <<< 1) + ko32;
      th_back   = kw32 + (kw32 <<< 1) + ko32;
      q32       = $signed({22'b0, screen_width_ff[11:2]});
      neg_q32   = -q32;
   end

   // Bar key decode from the position held at lift.
   always_comb begin
      bar_hit = (pos_y_ff > bar_top) && (pos_x_ff > 32'sd0);
      priority if (pos_x_ff < th_down) begin
         bar_code = ttg_pkg::BTN_DOWN;
      end else if (pos_x_ff < th_up) begin
         bar_code = ttg_pkg::BTN_UP;
      end else if (pos_x_ff < th_back) begin
         bar_code = ttg_pkg::BTN_BACK;
      end else begin
         bar_code = ttg_pkg::BTN_POWER;
      end
   end

   assign sum_add = tb_sum_ff + in_value_ff;
   assign mx_add  = (pos_x_ff != 32'sd0) ? motion_x_ff + (in_value_ff - pos_x_ff)
                                         : motion_x_ff;
   assign my_add  = (pos_y_ff != 32'sd0) ? motion_y_ff + (in_value_ff - pos_y_ff)
                                         : motion_y_ff;

   // Per-word decode: next gesture state and the key word it yields.
   always_comb begin
      tb_sum_in      = tb_sum_ff;
      finger_down_in = finger_down_ff;
      swipe_right_in = swipe_right_ff;
      swipe_left_in  = swipe_left_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      motion_x_in    = motion_x_ff;
      motion_y_in    = motion_y_ff;
      res_valid      = 1'b0;
      res_code       = in_code_ff;
      res_value      = in_value_ff;
      res_synth      = 1'b0;

      if (in_type_ff == ttg_pkg::EV_SYNC) begin
         // Sync words change nothing.
         res_valid = 1'b0;
      end else if (in_type_ff == ttg_pkg::EV_REL) begin
         // Trackball motion is summed until it crosses a threshold.
         if (in_code_ff == ttg_pkg::REL_Y_CODE) begin
            tb_sum_in = sum_add;
            if (sum_add > ttg_pkg::TRACK_POS_LIMIT) begin
               res_valid = 1'b1;
               res_synth = 1'b1;
               res_code  = ttg_pkg::BTN_DOWN;
               res_value = 32'sd1;
               tb_sum_in = '0;
            end else if (sum_add < ttg_pkg::TRACK_NEG_LIMIT) begin
               res_valid = 1'b1;
               res_synth = 1'b1;
               res_code  = ttg_pkg::BTN_UP;
               res_value = 32'sd1;
               tb_sum_in = '0;
            end
         end
      end else begin
         tb_sum_in = '0;
         if (in_type_ff == ttg_pkg::EV_KEY) begin
            // Real keys pass through when the code is in range.
            res_valid = (in_code_ff <= ttg_pkg::KEY_CODE_LIMIT);
         end else if (in_type_ff == ttg_pkg::EV_ABS) begin
            if (in_code_ff == ttg_pkg::TRACK_ID_CODE) begin
               if (in_value_ff != ttg_pkg::LIFT_ID) begin
                  // Touch down starts a fresh gesture.
                  if (!finger_down_ff) begin
                     finger_down_in = 1'b1;
                     pos_x_in       = '0;
                     pos_y_in       = '0;
                     motion_x_in    = '0;
                     motion_y_in    = '0;
                  end
               end else begin
                  // Lift: bar key, overridden by a pending swipe.
                  res_valid = 1'b1;
                  res_value = 32'sd1;
                  res_code  = bar_hit ? bar_code : ttg_pkg::TRACK_ID_CODE;
                  if (swipe_right_ff) begin
                     res_code       = ttg_pkg::BTN_POWER;
                     swipe_right_in = 1'b0;
                  end else if (swipe_left_ff) begin
                     res_code      = ttg_pkg::BTN_BACK;
                     swipe_left_in = 1'b0;
                  end
                  finger_down_in = 1'b0;
                  pos_x_in       = '0;
                  pos_y_in       = '0;
                  motion_x_in    = '0;
                  motion_y_in    = '0;
               end
            end else if (in_code_ff == ttg_pkg::ABS_X_CODE) begin
               // Horizontal motion arms a swipe.
               pos_x_in    = in_value_ff;
               motion_x_in = mx_add;
               if (pos_y_ff < bar_top) begin
                  if (mx_add > q32) begin
                     swipe_right_in = 1'b1;
                     pos_x_in       = '0;
                     pos_y_in       = '0;
                     motion_x_in    = '0;
                     motion_y_in    = '0;
                  end else if (mx_add < neg_q32) begin
                     swipe_left_in = 1'b1;
                     pos_x_in      = '0;
                     pos_y_in      = '0;
                     motion_x_in   = '0;
                     motion_y_in   = '0;
                  end
               end
            end else if (in_code_ff == ttg_pkg::ABS_Y_CODE) begin
               // Vertical motion emits a key at once, valued by the coordinate.
               pos_y_in    = in_value_ff;
               motion_y_in = my_add;
               if (in_value_ff < bar_top) begin
                  if (my_add > ttg_pkg::VERT_POS_LIMIT) begin
                     res_valid   = 1'b1;
                     res_code    = ttg_pkg::BTN_DOWN;
                     pos_x_in    = '0;
                     pos_y_in    = '0;
                     motion_x_in = '0;
                     motion_y_in = '0;
                  end else if (my_add < ttg_pkg::VERT_NEG_LIMIT) begin
                     res_valid   = 1'b1;
                     res_code    = ttg_pkg::BTN_UP;
                     pos_x_in    = '0;
                     pos_y_in    = '0;
                     motion_x_in = '0;
                     motion_y_in = '0;
                  end
               end
            end
         end
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= ttg_pkg::SCREEN_WIDTH_RST;
         screen_height_ff <= ttg_pkg::SCREEN_HEIGHT_RST;
         keybar_width_ff  <= ttg_pkg::KEYBAR_WIDTH_RST;
         keybar_height_ff <= ttg_pkg::KEYBAR_HEIGHT_RST;
      end else if (csr_wr_en) begin
         if (csr_index == ttg_pkg::CSR_SCREEN_WIDTH) begin
            screen_width_ff <= csr_wr_data;
         end
         if (csr_index == ttg_pkg::CSR_SCREEN_HEIGHT) begin
            screen_height_ff <= csr_wr_data;
         end
         if (csr_index == ttg_pkg::CSR_KEYBAR_WIDTH) begin
            keybar_width_ff <= csr_wr_data;
         end
         if (csr_index == ttg_pkg::CSR_KEYBAR_HEIGHT) begin
            keybar_height_ff <= csr_wr_data;
         end
      end
   end

   // Input register: loads whenever it is empty or drains this cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_type_ff  <= req_event_type;
         in_code_ff  <= req_event_code;
         in_value_ff <= req_event_value;
      end
   end

   // Gesture state commits when the word moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         tb_sum_ff      <= '0;
         finger_down_ff <= 1'b0;
         swipe_right_ff <= 1'b0;
         swipe_left_ff  <= 1'b0;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         motion_x_ff    <= '0;
         motion_y_ff    <= '0;
      end else if (advance) begin
         tb_sum_ff      <= tb_sum_in;
         finger_down_ff <= finger_down_in;
         swipe_right_ff <= swipe_right_in;
         swipe_left_ff  <= swipe_left_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         motion_x_ff    <= motion_x_in;
         motion_y_ff    <= motion_y_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= res_valid;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_code_ff  <= res_code;
         rsp_value_ff <= res_value;
         rsp_synth_ff <= res_synth;
      end
   end

endmodule

@@ sim/gesture_key_checker.sv @@
`timescale 1ns / 1ps

module gesture_key_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic [ttg_pkg::TypeWidth-1:0]          req_event_type,
   input  logic [ttg_pkg::CodeWidth-1:0]          req_event_code,
   input  logic signed [ttg_pkg::ValueWidth-1:0]  req_event_value,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [ttg_pkg::CodeWidth-1:0]          rsp_key_code,
   input  logic signed [ttg_pkg::ValueWidth-1:0]  rsp_key_value,
   input  logic                                   rsp_synthetic,
   input  logic                                   csr_wr_en,
   input  logic [ttg_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [ttg_pkg::CsrWidth-1:0]           csr_wr_data,
   output int                                     mismatches,
   output int                                     keys_pending
);

   typedef struct packed {
      logic [ttg_pkg::CodeWidth-1:0]         code;
      logic signed [ttg_pkg::ValueWidth-1:0] value;
      logic                                  synthetic;
   } key_event_type;

   // Shadow copy of the screen geometry and of the gesture state.
   logic [ttg_pkg::CsrWidth-1:0]   scr_w, scr_h, bar_w, bar_h;
   logic [ttg_pkg::ValueWidth-1:0] ball_sum, pos_x, pos_y, mot_x, mot_y;
   logic                           finger_down, swipe_right, swipe_left;

   // Key words still owed by the block, oldest first.
   key_event_type key_events_due[$];

   function automatic void clear_motion();
      pos_x = '0;
      pos_y = '0;
      mot_x = '0;
      mot_y = '0;
   endfunction

   // Applies one input word to the shadow state; returns 1 when a key word is due.
   function automatic bit decode_gesture_event(
      input  logic [ttg_pkg::TypeWidth-1:0]  etype,
      input  logic [ttg_pkg::CodeWidth-1:0]  ecode,
      input  logic [ttg_pkg::ValueWidth-1:0] evalue,
      output key_event_type                  ev
   );
      logic [ttg_pkg::CodeWidth-1:0]  code;
      logic [ttg_pkg::ValueWidth-1:0] value;
      logic [ttg_pkg::ValueWidth-1:0] prev;
      bit                             is_key;
      bit                             synth;
      longint                         bar_top, key_w, key_off, x, y, quarter;
      ev = '0;
      code = ecode;
      value = evalue;
      is_key = 1'b0;
      synth = 1'b0;
      bar_top = longint'(scr_h) - longint'(bar_h);

      if (etype == ttg_pkg::EV_SYNC) return 1'b0;

      // Trackball motion accumulates; every other class but sync clears the sum.
      if (etype == ttg_pkg::EV_REL) begin
         if (ecode == ttg_pkg::REL_Y_CODE) begin
            ball_sum = ball_sum + evalue;
            if ($signed(ball_sum) > ttg_pkg::TRACK_POS_LIMIT) begin
               is_key = 1'b1;
               synth = 1'b1;
               code = ttg_pkg::BTN_DOWN;
               value = 32'd1;
               ball_sum = '0;
            end else if ($signed(ball_sum) < ttg_pkg::TRACK_NEG_LIMIT) begin
               is_key = 1'b1;
               synth = 1'b1;
               code = ttg_pkg::BTN_UP;
               value = 32'd1;
               ball_sum = '0;
            end
         end
      end else begin
         ball_sum = '0;
         if (etype == ttg_pkg::EV_KEY) is_key = 1'b1;
      end

      if (etype == ttg_pkg::EV_ABS && ecode == ttg_pkg::TRACK_ID_CODE &&
          $signed(evalue) != ttg_pkg::LIFT_ID) begin
         // Finger down; a second id while touching is ignored.
         if (!finger_down) begin
            finger_down = 1'b1;
            clear_motion();
         end
      end else if (etype == ttg_pkg::EV_ABS && ecode == ttg_pkg::TRACK_ID_CODE) begin
         // Lift: decode the bar key, then let a pending swipe override it.
         key_w = longint'(bar_w) / 4;
         key_off = (longint'(scr_w) - longint'(bar_w)) / 2;
         x = longint'($signed(pos_x));
         y = longint'($signed(pos_y));
         is_key = 1'b1;
         if (y > bar_top && x > 0) begin
            if (x < key_w + key_off) code = ttg_pkg::BTN_DOWN;
            else if (x < key_w * 2 + key_off) code = ttg_pkg::BTN_UP;
            else if (x < key_w * 3 + key_off) code = ttg_pkg::BTN_BACK;
            else code = ttg_pkg::BTN_POWER;
         end
         if (swipe_right) begin
            code = ttg_pkg::BTN_POWER;
            swipe_right = 1'b0;
         end else if (swipe_left) begin
            code = ttg_pkg::BTN_BACK;
            swipe_left = 1'b0;
         end
         value = 32'd1;
         finger_down = 1'b0;
         clear_motion();
      end else if (etype == ttg_pkg::EV_ABS && ecode == ttg_pkg::ABS_X_CODE) begin
         // Horizontal motion arms a swipe above the key bar.
         prev = pos_x;
         pos_x = evalue;
         if (prev != 0) mot_x = mot_x + evalue - prev;
         if (longint'($signed(pos_y)) < bar_top) begin
            quarter = longint'(scr_w) / 4;
            if (longint'($signed(mot_x)) > quarter) begin
               swipe_right = 1'b1;
               clear_motion();
            end else if (longint'($signed(mot_x)) < -quarter) begin
               swipe_left = 1'b1;
               clear_motion();
            end
         end
      end else if (etype == ttg_pkg::EV_ABS && ecode == ttg_pkg::ABS_Y_CODE) begin
         // Vertical motion emits a key at once, carrying the coordinate.
         prev = pos_y;
         pos_y = evalue;
         if (prev != 0) mot_y = mot_y + evalue - prev;
         if (longint'($signed(pos_y)) < bar_top) begin
            if ($signed(mot_y) > ttg_pkg::VERT_POS_LIMIT) begin
               is_key = 1'b1;
               code = ttg_pkg::BTN_DOWN;
               clear_motion();
            end else if ($signed(mot_y) < ttg_pkg::VERT_NEG_LIMIT) begin
               is_key = 1'b1;
               code = ttg_pkg::BTN_UP;
               clear_motion();
            end
         end
      end

      if (!is_key || code > ttg_pkg::KEY_CODE_LIMIT) return 1'b0;
      ev.code = code;
      ev.value = value;
      ev.synthetic = synth;
      return 1'b1;
   endfunction

   // Outputs are checked before the input word of the same edge is predicted.
   always @(posedge clock) begin
      key_event_type want;
      key_event_type fresh;
      if (reset) begin
         scr_w = ttg_pkg::SCREEN_WIDTH_RST;
         scr_h = ttg_pkg::SCREEN_HEIGHT_RST;
         bar_w = ttg_pkg::KEYBAR_WIDTH_RST;
         bar_h = ttg_pkg::KEYBAR_HEIGHT_RST;
         ball_sum = '0;
         finger_down = 1'b0;
         swipe_right = 1'b0;
         swipe_left = 1'b0;
         clear_motion();
         key_events_due.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (key_events_due.size() == 0) begin
               $display("%0t: unexpected key word, code %0d value %0d synthetic %0b",
                        $time, rsp_key_code, rsp_key_value, rsp_synthetic);
               mismatches++;
            end else begin
               want = key_events_due.pop_front();
               if (rsp_key_code !== want.code) begin
                  $display("%0t: key_code expected %0d, got %0d",
                           $time, want.code, rsp_key_code);
                  mismatches++;
               end
               if (rsp_key_value !== want.value) begin
                  $display("%0t: key_value expected %0d, got %0d",
                           $time, want.value, rsp_key_value);
                  mismatches++;
               end
               if (rsp_synthetic !== want.synthetic) begin
                  $display("%0t: synthetic expected %0b, got %0b",
                           $time, want.synthetic, rsp_synthetic);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (decode_gesture_event(req_event_type, req_event_code, req_event_value,
                                     fresh))
               key_events_due.push_back(fresh);
         end
         if (csr_wr_en) begin
            case (csr_index)
               ttg_pkg::CSR_SCREEN_WIDTH:  scr_w = csr_wr_data;
               ttg_pkg::CSR_SCREEN_HEIGHT: scr_h = csr_wr_data;
               ttg_pkg::CSR_KEYBAR_WIDTH:  bar_w = csr_wr_data;
               ttg_pkg::CSR_KEYBAR_HEIGHT: bar_h = csr_wr_data;
               default: ;
            endcase
         end
      end
      keys_pending = key_events_due.size();
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int HOLD_CYCLES    = 100;
   localparam int PHASE_WORDS    = 150;
   localparam logic [ttg_pkg::CsrIdxWidth-1:0] CSR_SPARE = 3'd5;

   typedef logic [ttg_pkg::TypeWidth-1:0] evtype_type;
   typedef logic [ttg_pkg::CodeWidth-1:0] code_type;
   typedef logic [ttg_pkg::CsrWidth-1:0]  csr_type;

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_stall;
   logic [ttg_pkg::TypeWidth-1:0]          req_event_type;
   logic [ttg_pkg::CodeWidth-1:0]          req_event_code;
   logic signed [ttg_pkg::ValueWidth-1:0]  req_event_value;
   logic                                   rsp_valid;
   logic                                   rsp_stall;
   logic [ttg_pkg::CodeWidth-1:0]          rsp_key_code;
   logic signed [ttg_pkg::ValueWidth-1:0]  rsp_key_value;
   logic                                   rsp_synthetic;
   logic                                   csr_wr_en;
   logic [ttg_pkg::CsrIdxWidth-1:0]        csr_index;
   logic [ttg_pkg::CsrWidth-1:0]           csr_wr_data;

   int mismatches;
   int keys_pending;
   int words_sent;
   int cfg_table[6][4];
   int scr_w = 480;
   int scr_h = 800;
   int bar_h = 72;
   bit sender_gaps = 1'b1;
   bit rsp_stalls_on = 1'b1;
   bit hold_rsp = 1'b0;

   touch_trackball_gesture_to_key DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_event_type  (req_event_type),
      .req_event_code  (req_event_code),
      .req_event_value (req_event_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_code    (rsp_key_code),
      .rsp_key_value   (rsp_key_value),
      .rsp_synthetic   (rsp_synthetic),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   gesture_key_checker u_key_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_event_type  (req_event_type),
      .req_event_code  (req_event_code),
      .req_event_value (req_event_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_code    (rsp_key_code),
      .rsp_key_value   (rsp_key_value),
      .rsp_synthetic   (rsp_synthetic),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .mismatches      (mismatches),
      .keys_pending    (keys_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Ends the run when neither channel nor the register port moves for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   // Result side: random stalls, quiet stretches, and one long hold on request.
   initial begin : key_sink
      int r;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_stall = 1'b0;
         end else if (!rsp_stalls_on) begin
            rsp_stall = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_stall = 1'b0;
            end else if (r < 97) begin
               rsp_stall = 1'b1;
            end else begin
               rsp_stall = 1'b1;
               repeat ($urandom_range(8, 30)) @(negedge clock);
            end
         end
      end
   end

   // Mostly back-to-back words, sometimes a short pause, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // Offers one input word and returns once the block has taken it.
   task automatic send_event(input logic [ttg_pkg::TypeWidth-1:0] etype,
                             input logic [ttg_pkg::CodeWidth-1:0] ecode,
                             input logic [ttg_pkg::ValueWidth-1:0] evalue);
      int gap;
      @(negedge clock);
      gap = sender_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_event_type = etype;
      req_event_code = ecode;
      req_event_value = evalue;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // Stops offering words and waits until the block has nothing left in flight.
   task automatic drain_block();
      @(negedge clock);
      req_valid = 1'b0;
      wait (keys_pending == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [ttg_pkg::CsrIdxWidth-1:0] idx,
                            input logic [ttg_pkg::CsrWidth-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = data;
      @(posedge clock);
   endtask

   task automatic program_screen(input int w, input int h, input int bw, input int bh);
      drain_block();
      write_csr(ttg_pkg::CSR_SCREEN_WIDTH, csr_type'(w));
      write_csr(ttg_pkg::CSR_SCREEN_HEIGHT, csr_type'(h));
      write_csr(ttg_pkg::CSR_KEYBAR_WIDTH, csr_type'(bw));
      write_csr(ttg_pkg::CSR_KEYBAR_HEIGHT, csr_type'(bh));
      write_csr(CSR_SPARE, csr_type'($urandom));
      @(negedge clock);
      csr_wr_en = 1'b0;
      scr_w = w;
      scr_h = h;
      bar_h = bh;
   endtask

   // Next coordinate: a step from the last one, a spot on screen, zero or anything.
   function automatic int next_coord(input int last, input int step, input int span);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 0;
         2, 3, 4, 5: return last + int'($urandom_range(0, 2 * step)) - step;
         default: return $urandom_range(0, span);
      endcase
   endfunction

   // Finger down, a few moves with syncs between, sometimes a bar touch, then usually a lift.
   task automatic touch_gesture();
      int moves;
      int x;
      int y;
      x = 0;
      y = 0;
      moves = $urandom_range(1, 8);
      if ($urandom_range(0, 3) == 0)
         send_event(ttg_pkg::EV_ABS, ttg_pkg::TRACK_ID_CODE, $urandom);
      else
         send_event(ttg_pkg::EV_ABS, ttg_pkg::TRACK_ID_CODE, $urandom_range(0, 15));
      repeat (moves) begin
         if ($urandom_range(0, 1)) begin
            x = next_coord(x, scr_w / 3 + 1, scr_w);
            send_event(ttg_pkg::EV_ABS, ttg_pkg::ABS_X_CODE, x);
         end else begin
            y = next_coord(y, 60, scr_h);
            send_event(ttg_pkg::EV_ABS, ttg_pkg::ABS_Y_CODE, y);
         end
         if ($urandom_range(0, 3) == 0) send_event(ttg_pkg::EV_SYNC, '0, '0);
      end
      if ($urandom_range(0, 2) == 0) begin
         send_event(ttg_pkg::EV_ABS, ttg_pkg::ABS_X_CODE, $urandom_range(0, scr_w));
         send_event(ttg_pkg::EV_ABS, ttg_pkg::ABS_Y_CODE,
                    scr_h - int'($urandom_range(0, bar_h + 1)));
      end
      if ($urandom_range(0, 9) != 0)
         send_event(ttg_pkg::EV_ABS, ttg_pkg::TRACK_ID_CODE, ttg_pkg::LIFT_ID);
   endtask

   task automatic trackball_burst();
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 9))
            0: send_event(ttg_pkg::EV_REL, code_type'($urandom_range(0, 1023)), $urandom);
            1: send_event(ttg_pkg::EV_REL, ttg_pkg::REL_Y_CODE, $urandom);
            default: send_event(ttg_pkg::EV_REL, ttg_pkg::REL_Y_CODE,
                                int'($urandom_range(0, 6)) - 3);
         endcase
      end
   endtask

   task automatic key_press();
      logic [ttg_pkg::CodeWidth-1:0]  code;
      logic [ttg_pkg::ValueWidth-1:0] value;
      code = ($urandom_range(0, 4) == 0) ? code_type'($urandom_range(768, 1023))
                                         : code_type'($urandom_range(0, 767));
      value = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 2);
      send_event(ttg_pkg::EV_KEY, code, value);
   endtask

   initial begin : stimulus
      int target;
      int r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_event_type = '0;
      req_event_code = '0;
      req_event_value = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      words_sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part on the default geometry: bar top 728, keys 120 wide.
      send_event(ttg_pkg::EV_SYNC, '0, '0);
      send_event(ttg_pkg::EV_KEY, '0, 32'd1);
      send_event(ttg_pkg::EV_KEY, ttg_pkg::KEY_CODE_LIMIT, 32'd0);
      send_event(ttg_pkg::EV_KEY, ttg_pkg::KEY_CODE_LIMIT + 10'd1, 32'd1);
      send_event(ttg_pkg::EV_KEY, 10'h3FF, 32'hFFFF_FFFF);
      send_event(ttg_pkg::EV_REL, ttg_pkg::REL_Y_CODE, 32'd2);
      send_event(ttg_pkg::EV_REL, ttg_pkg::REL_Y_CODE, 32'd2);
      send_event(ttg_pkg::EV_REL, ttg_pkg::REL_Y_CODE, -32'sd4);
      send_event(ttg_pkg::EV_REL, ttg_pkg::REL_Y_CODE, 32'd3);
      send_event(5'd31, '0, '0);
      send_event(ttg_pkg::EV_REL, ttg_pkg::REL_Y_CODE, 32'd3);
      // The sum wraps past the top of the signed range.
      send_event(ttg_pkg::EV_REL, ttg_pkg::REL_Y_CODE, 32'h7FFF_FFFF);
      // Lift without a touch, then an unused absolute code.
      send_event(ttg_pkg::EV_ABS, ttg_pkg::TRACK_ID_CODE, ttg_pkg::LIFT_ID);
      send_event(ttg_pkg::EV_ABS, 10'd0, 32'd5);
      // Right swipe, a repeated finger-down, then lift.
      send_event(ttg_pkg::EV_ABS, ttg_pkg::TRACK_ID_CODE, 32'd0);
      send_event(ttg_pkg::EV_ABS, ttg_pkg::ABS_X_CODE, 32'd100);
      send_event(ttg_pkg::EV_ABS, ttg_pkg::ABS_X_CODE, 32'd300);
      send_event(ttg_pkg::EV_ABS, ttg_pkg::TRACK_ID_CODE, 32'd7);
      send_event(ttg_pkg::EV_ABS, ttg_pkg::TRACK_ID_CODE, ttg_pkg::LIFT_ID);
      // Upward motion to a negative Y, then a left swipe and lift.
      send_event(ttg_pkg::EV_ABS, ttg_pkg::TRACK_ID_CODE, 32'd1);
      send_event(ttg_pkg::EV_ABS, ttg_pkg::ABS_Y_CODE, 32'd10);
      send_event(ttg_pkg::EV_ABS, ttg_pkg::ABS_Y_CODE, -32'sd40);
      send_event(ttg_pkg::EV_ABS, ttg_pkg::ABS_X_CODE, 32'd400);
      send_event(ttg_pkg::EV_ABS, ttg_pkg::ABS_X_CODE, 32'd100);
      send_event(ttg_pkg::EV_ABS, ttg_pkg::TRACK_ID_CODE, ttg_pkg::LIFT_ID);
      // A touch on the second bar key.
      send_event(ttg_pkg::EV_ABS, ttg_pkg::TRACK_ID_CODE, 32'd2);
      send_event(ttg_pkg::EV_ABS, ttg_pkg::ABS_X_CODE, 32'd200);
      send_event(ttg_pkg::EV_ABS, ttg_pkg::ABS_Y_CODE, 32'd790);
      send_event(ttg_pkg::EV_ABS, ttg_pkg::TRACK_ID_CODE, ttg_pkg::LIFT_ID);

      cfg_table[0] = '{480, 800, 480, 72};
      cfg_table[1] = '{1, 1, 0, 0};
      cfg_table[2] = '{4095, 4095, 4095, 4095};
      cfg_table[3] = '{320, 480, 320, 48};
      cfg_table[4] = '{100, 200, 400, 4095};
      cfg_table[5][0] = $urandom_range(1, 4095);
      cfg_table[5][1] = $urandom_range(1, 4095);
      cfg_table[5][2] = $urandom_range(0, 4095);
      cfg_table[5][3] = $urandom_range(0, 4095);

      // Random phases, each on its own geometry and idling pattern.
      for (int phase = 0; phase < 6; phase++) begin
         program_screen(cfg_table[phase][0], cfg_table[phase][1],
                        cfg_table[phase][2], cfg_table[phase][3]);
         sender_gaps = (phase % 3 != 1);
         rsp_stalls_on = (phase % 3 != 2);
         if (phase == 0) begin
            // Hold the result side while key words keep coming, so the block backs up.
            sender_gaps = 1'b0;
            hold_rsp = 1'b1;
            repeat (24) send_event(ttg_pkg::EV_KEY, code_type'($urandom_range(0, 767)),
                                   $urandom_range(0, 1));
            sender_gaps = 1'b1;
         end
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 45) touch_gesture();
            else if (r < 62) trackball_burst();
            else if (r < 80) key_press();
            else send_event(evtype_type'($urandom_range(0, 31)),
                            code_type'($urandom_range(0, 1023)), $urandom);
         end
      end

      drain_block();
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
